// ===== rtl/core/mnst_pkg.sv =====
// Shared types and constants of the note slot table.
`timescale 1ns / 1ps

package mnst_pkg;

   // Message kind codes on the request channel
   localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [1:0] KIND_CTRL     = 2'd2;

   // Controller number that carries the modulation level
   localparam logic [6:0] MOD_CTRL = 7'd1;

   localparam int NOTES_DEFAULT = 16;

   // Command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_TAKE,
      OP_FREE,
      OP_MOD
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] pitch;
      logic [6:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } back_state_type;

endpackage

// ===== rtl/core/mnst_if.sv =====
// Request and response channel interfaces of the note slot table.
`timescale 1ns / 1ps

interface mnst_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [6:0] pitch;
   logic [6:0] velocity;
   logic [6:0] controller;
   logic [6:0] ctrl_value;

   modport source(output valid, kind, pitch, velocity, controller, ctrl_value, input ready);
   modport sink(input valid, kind, pitch, velocity, controller, ctrl_value, output ready);
endinterface

interface mnst_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] slot;
   logic       changed;
   logic [4:0] active_count;
   logic [6:0] mod_level;
   logic       analyze_req;

   modport source(output valid, slot, changed, active_count, mod_level, analyze_req,
                  input ready);
   modport sink(input valid, slot, changed, active_count, mod_level, analyze_req,
                output ready);
endinterface

// ===== rtl/core/mnst_front.sv =====
// Front end: accept request beats and turn them into table commands.
`timescale 1ns / 1ps

module mnst_front (
   mnst_req_if.sink          req_chan,
   input  mnst_pkg::q_status_type q_status,
   output logic              push,
   output mnst_pkg::cmd_type push_cmd
);
   import mnst_pkg::*;

   op_type op;

   always_comb begin
      case (req_chan.kind)
         KIND_NOTE_ON: begin
            op = (req_chan.velocity != 7'd0) ? OP_TAKE : OP_NONE;
         end
         KIND_NOTE_OFF: begin
            op = OP_FREE;
         end
         KIND_CTRL: begin
            op = (req_chan.controller == MOD_CTRL) ? OP_MOD : OP_NONE;
         end
         default: begin
            op = OP_NONE;
         end
      endcase
   end

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;
   assign push_cmd.op    = op;
   assign push_cmd.pitch = req_chan.pitch;
   assign push_cmd.value = req_chan.ctrl_value;

endmodule

// ===== rtl/core/mnst_queue.sv =====
// Short command queue between the front end and the slot engine.
`timescale 1ns / 1ps

module mnst_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mnst_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output mnst_pkg::cmd_type      head_cmd,
   output mnst_pkg::q_status_type q_status
);
   import mnst_pkg::*;

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !q_status.full;
      do_pop    = pop && !q_status.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/mnst_back.sv =====
// Slot engine: scan the slot table one slot a cycle and emit one result per command.
`timescale 1ns / 1ps

module mnst_back #(
   parameter int NOTES = mnst_pkg::NOTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mnst_pkg::cmd_type      head_cmd,
   input  mnst_pkg::q_status_type q_status,
   output logic                   pop,
   mnst_rsp_if.source             rsp_chan
);
   import mnst_pkg::*;

   localparam int IDX_W = (NOTES > 1) ? $clog2(NOTES) : 1;
   localparam int CNT_W = $clog2(NOTES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTES - 1);

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             issue_on_ff, issue_on_in;
   logic             stage_vld_ff, stage_vld_in;
   logic [IDX_W-1:0] idx_q_ff;
   logic             act_q_ff;
   logic [6:0]       pitch_q_ff;
   logic [NOTES-1:0] active_ff, active_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [6:0]       mod_ff, mod_in;
   logic             changed_ff, changed_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;
   logic             hit, scan_end, mem_we;

   logic [6:0]       pitch_mem [NOTES];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               if (head_cmd.op inside {OP_TAKE, OP_FREE}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      hit = stage_vld_ff &&
            ((cmd_ff.op == OP_TAKE) ? !act_q_ff
                                    : (act_q_ff && pitch_q_ff == cmd_ff.pitch));
      scan_end = stage_vld_ff && (hit || idx_q_ff == LAST_IDX);
      mem_we   = hit && (cmd_ff.op == OP_TAKE);
      rsp_load = !rsp_valid_ff || rsp_chan.ready;

      pop          = 1'b0;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      issue_on_in  = issue_on_ff;
      stage_vld_in = 1'b0;
      active_in    = active_ff;
      count_in     = count_ff;
      mod_in       = mod_ff;
      changed_in   = changed_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop         = 1'b1;
               cmd_in      = head_cmd;
               idx_in      = '0;
               issue_on_in = 1'b1;
               changed_in  = 1'b0;
               res_slot_in = '0;
               if (head_cmd.op == OP_MOD) begin
                  mod_in = head_cmd.value;
               end
            end
         end
         ST_SCAN: begin
            if (issue_on_ff && !scan_end) begin
               stage_vld_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end
            end
            if (hit) begin
               issue_on_in = 1'b0;
               changed_in  = 1'b1;
               res_slot_in = idx_q_ff;
               if (cmd_ff.op == OP_TAKE) begin
                  active_in[idx_q_ff] = 1'b1;
                  count_in            = count_ff + 1'b1;
               end else begin
                  active_in[idx_q_ff] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_on_ff  <= 1'b0;
         stage_vld_ff <= 1'b0;
         active_ff    <= '0;
         count_ff     <= '0;
         mod_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_on_ff  <= issue_on_in;
         stage_vld_ff <= stage_vld_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      idx_q_ff    <= idx_ff;
      act_q_ff    <= active_ff[idx_ff];
      changed_ff  <= changed_in;
      res_slot_ff <= res_slot_in;
      if (state_ff == ST_EMIT && rsp_load) begin
         rsp_chan.slot         <= 4'(res_slot_ff);
         rsp_chan.changed      <= changed_ff;
         rsp_chan.active_count <= (32'(count_ff) > 32'd31) ? 5'd31 : 5'(count_ff);
         rsp_chan.mod_level    <= mod_ff;
         rsp_chan.analyze_req  <= (count_ff != '0);
      end
   end

   // Pitch store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pitch_mem[idx_q_ff] <= cmd_ff.pitch;
      end
      pitch_q_ff <= pitch_mem[idx_ff];
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

// ===== rtl/core/midi_note_slot_table_unit.sv =====
// Top level of the MIDI note slot table: front end, command queue and slot engine.
`timescale 1ns / 1ps

// Keeps NOTES note slots (active mark and pitch), the number of active notes and
// the last modulation level (controller 1). Every request beat gives exactly one
// response beat, in order. A note-on with nonzero velocity takes the lowest free
// slot and is dropped when all are busy; a note-off frees the lowest active slot
// holding its pitch; a control change on controller 1 stores its value; anything
// else changes nothing. The response carries the slot taken or freed (low four
// bits, zero when none), a changed flag, the active count (saturating at 31),
// the modulation level and an analyse request that is set while any note is
// active. In the slot engine a note-on or note-off message is fetched from the
// queue, walks the slots one a cycle through the pitch store's read port and
// then loads its result; the walk finishes early on a match. Other messages go
// straight to loading the result. A two-entry command queue lets the request
// side run ahead of the engine, and a response register lets the engine start
// the next command while the last result waits. No clearing pass is needed
// after reset: pitches are only compared in slots whose active mark is set,
// and those were written when taken.
module midi_note_slot_table_unit #(
   parameter int NOTES = mnst_pkg::NOTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mnst_req_if.sink    req_chan,
   mnst_rsp_if.source  rsp_chan
);
   import mnst_pkg::*;

   logic         push;
   cmd_type      push_cmd;
   logic         pop;
   cmd_type      head_cmd;
   q_status_type q_status;

   // Classify each request beat and hand it to the queue
   mnst_front u_front (
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // Hold commands until the slot engine is free
   mnst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // Walk the slot table and drive the response beat
   mnst_back #(
      .NOTES (NOTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
